>>> design/pcpv_pkg.sv
// Shared types and constants for the proximity presence voter.
package pcpv_pkg;

    localparam int unsigned STRENGTH_W = 8;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned VOTE_OUT_W = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'hFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_STRENGTH_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_COUNT_MIN = 1'd1;

    localparam logic signed [STRENGTH_W-1:0] CLOSE_STRENGTH_MIN_RST = -8'sd71;
    localparam logic [COUNT_W-1:0]           PRESENCE_COUNT_MIN_RST = 8'd3;

    typedef struct packed {
        logic                         has_device;
        logic signed [STRENGTH_W-1:0] strength;
        logic                         scan_end;
    } t_in_item;

    typedef struct packed {
        logic [VOTE_OUT_W-1:0] votes_held;
        logic [VOTE_OUT_W-1:0] present_votes;
        logic [COUNT_W-1:0]    close_count;
        logic                  changed;
        logic                  present;
    } t_result;

    typedef struct packed {
        logic close_vote;
        logic present;
        logic changed;
    } t_decision;

endpackage

>>> design/pcpv_scan_counter.sv
// Per-scan close-device counter and scan vote.
module pcpv_scan_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  pcpv_pkg::t_in_item                 i_item,
    input  logic signed [pcpv_pkg::STRENGTH_W-1:0] i_close_strength_min,
    input  logic [pcpv_pkg::COUNT_W-1:0]       i_presence_count_min,
    output logic [pcpv_pkg::COUNT_W-1:0]       o_close_count,
    output logic                               o_vote
);

    logic [pcpv_pkg::COUNT_W-1:0] r_scan_count;
    logic [pcpv_pkg::COUNT_W-1:0] n_scan_count;
    logic                         w_close;

    // zero strength means unknown distance and counts as close
    assign w_close = i_item.has_device &&
                     ((i_item.strength == '0) || (i_item.strength >= i_close_strength_min));

    always_comb begin
        o_close_count = r_scan_count;
        if (w_close && (r_scan_count != pcpv_pkg::COUNT_LIMIT)) begin
            o_close_count = r_scan_count + 1'b1;
        end
    end

    assign o_vote = (o_close_count >= i_presence_count_min);

    always_comb begin
        n_scan_count = r_scan_count;
        if (i_step) begin
            n_scan_count = i_item.scan_end ? '0 : o_close_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_count <= '0;
        end else begin
            r_scan_count <= n_scan_count;
        end
    end

endmodule

>>> design/pcpv_vote_window.sv
// Ring of scan votes with running vote count, fill level and presence flag.
module pcpv_vote_window #(
    parameter int unsigned WINDOW_SLOTS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_vote,
    output logic [$clog2(WINDOW_SLOTS+1)-1:0]   o_votes,
    output logic [$clog2(WINDOW_SLOTS+1)-1:0]   o_held,
    output pcpv_pkg::t_decision                 o_decision
);

    localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);
    localparam int unsigned PTR_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    logic [WINDOW_SLOTS-1:0] r_ring;
    logic [PTR_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        r_votes;
    logic [CNT_W-1:0]        r_fill;
    logic                    r_present;

    logic [CNT_W-1:0]        n_votes;
    logic [CNT_W-1:0]        n_fill;
    logic [PTR_W-1:0]        n_ptr;
    logic                    n_present;

    // slot being overwritten leaves the count, new vote joins it
    assign n_votes = r_votes - CNT_W'(r_ring[r_ptr]) + CNT_W'(i_vote);
    assign n_fill  = (r_fill == CNT_W'(WINDOW_SLOTS)) ? r_fill : r_fill + 1'b1;
    assign n_ptr   = (r_ptr == PTR_W'(WINDOW_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign n_present = ({n_votes, 1'b0} >= {1'b0, n_fill});

    assign o_votes               = n_votes;
    assign o_held                = n_fill;
    assign o_decision.close_vote = i_vote;
    assign o_decision.present    = n_present;
    assign o_decision.changed    = n_present ^ r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring    <= '0;
            r_ptr     <= '0;
            r_votes   <= '0;
            r_fill    <= '0;
            r_present <= 1'b0;
        end else if (i_push) begin
            r_ring[r_ptr] <= i_vote;
            r_ptr         <= n_ptr;
            r_votes       <= n_votes;
            r_fill        <= n_fill;
            r_present     <= n_present;
        end
    end

endmodule

>>> design/proximity_count_presence_voter.sv
// Top level: input register, configuration, scan counter, vote window, result register.
// Path: a scan-end item is registered at the input, its result in the result register.
// Throughput: one item per cycle; items that end no scan are consumed even while a result
// waits, so only a scan-end item can be held up by a stalled output.
// Reset (i_rst_n low, synchronous): ring, pointer, fill level, scan count and presence clear,
// configuration returns to close_strength_min -71 and presence_count_min 3.
module proximity_count_presence_voter #(
    parameter int unsigned WINDOW_SLOTS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pcpv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcpv_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // device report stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] strength
    input  logic                                s_tuser,   // [0] has_device
    input  logic                                s_tlast,   // scan_end
    // presence result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] present, [1] changed, [9:2] close_count, [13:10] present_votes,
    // [17:14] votes_held, [23:18] zero
    output logic [pcpv_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);
    localparam int unsigned RES_W = $bits(pcpv_pkg::t_result);

    logic signed [pcpv_pkg::STRENGTH_W-1:0] r_close_strength_min;
    logic [pcpv_pkg::COUNT_W-1:0]           r_presence_count_min;

    logic                  r_in_valid;
    pcpv_pkg::t_in_item    r_in;
    logic                  r_out_valid;
    pcpv_pkg::t_result     r_out;

    logic                  w_out_free;
    logic                  w_step;
    logic                  w_push;
    logic [pcpv_pkg::COUNT_W-1:0] w_close_count;
    logic                  w_vote;
    logic [CNT_W-1:0]      w_votes;
    logic [CNT_W-1:0]      w_held;
    pcpv_pkg::t_decision   w_decision;
    pcpv_pkg::t_result     w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_strength_min <= pcpv_pkg::CLOSE_STRENGTH_MIN_RST;
            r_presence_count_min <= pcpv_pkg::PRESENCE_COUNT_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcpv_pkg::CFG_CLOSE_STRENGTH_MIN: r_close_strength_min <= i_cfg_wdata;
                pcpv_pkg::CFG_PRESENCE_COUNT_MIN: r_presence_count_min <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a scan-end item needs room in the result register, others never wait
    assign w_out_free = !r_out_valid || m_tready;
    assign w_step     = r_in_valid && (!r_in.scan_end || w_out_free);
    assign w_push     = w_step && r_in.scan_end;
    assign s_tready   = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in.has_device <= s_tuser;
            r_in.strength   <= s_tdata;
            r_in.scan_end   <= s_tlast;
        end
    end

    pcpv_scan_counter u_scan_counter (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (w_step),
        .i_item               (r_in),
        .i_close_strength_min (r_close_strength_min),
        .i_presence_count_min (r_presence_count_min),
        .o_close_count        (w_close_count),
        .o_vote               (w_vote)
    );

    pcpv_vote_window #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_vote_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_vote     (w_vote),
        .o_votes    (w_votes),
        .o_held     (w_held),
        .o_decision (w_decision)
    );

    assign w_result.present       = w_decision.present;
    assign w_result.changed       = w_decision.changed;
    assign w_result.close_count   = w_close_count;
    assign w_result.present_votes = pcpv_pkg::VOTE_OUT_W'(w_votes);
    assign w_result.votes_held    = pcpv_pkg::VOTE_OUT_W'(w_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(pcpv_pkg::OUT_TDATA_W - RES_W){1'b0}}, r_out};

    // the window never counts more present votes than filled slots
    a_votes_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_votes <= w_held))
        else $error("present votes exceed filled slots");

    // at least one slot is filled once a scan has closed
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_held != '0))
        else $error("fill level zero at scan end");

    // input back-pressure only comes from a scan end waiting on a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_in_valid && r_in.scan_end && r_out_valid && !m_tready))
        else $error("input stalled without a pending result");

    // the vote passed to the window agrees with the close count and threshold
    a_vote_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_decision.close_vote == (w_close_count >= r_presence_count_min)))
        else $error("scan vote disagrees with close count");

endmodule

>>> tb/presence_vote_checker.sv
// Checker for the presence voter: predicts each scan result and compares the output stream.
module presence_vote_checker
    import pcpv_pkg::*;
#(
    parameter int unsigned VOTE_SLOTS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [7:0]                 i_in_data,   // [7:0] strength
    input  logic                       i_in_user,   // [0] has_device
    input  logic                       i_in_last,   // scan_end
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    // [0] present, [1] changed, [9:2] close_count, [13:10] present_votes,
    // [17:14] votes_held, [23:18] zero
    input  logic [OUT_TDATA_W-1:0]     i_out_data,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);

    // own copy of the block's configuration and window state
    logic signed [STRENGTH_W-1:0] close_min;
    logic [COUNT_W-1:0]           count_min;
    logic [VOTE_SLOTS-1:0]        vote_window;
    logic [3:0]                   window_ptr;
    logic [3:0]                   window_fill;
    logic [COUNT_W-1:0]           close_in_scan;
    logic                         presence_now;

    t_result expected_decisions[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result                      got;
        t_result                      want;
        logic signed [STRENGTH_W-1:0] rssi;
        logic                         vote;
        int                           votes;

        if (!i_rst_n) begin
            close_min     = CLOSE_STRENGTH_MIN_RST;
            count_min     = PRESENCE_COUNT_MIN_RST;
            vote_window   = '0;
            window_ptr    = '0;
            window_fill   = '0;
            close_in_scan = '0;
            presence_now  = 1'b0;
            expected_decisions.delete();
        end else begin
            // a result transaction always belongs to an earlier scan end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[$bits(t_result)-1:0];
                if (expected_decisions.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("presence result with none expected: tdata=%h", i_out_data);
                end else begin
                    want = expected_decisions.pop_front();
                    if (got !== want || i_out_data[OUT_TDATA_W-1:$bits(t_result)] !== '0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("presence result mismatch: expected present=%0d changed=%0d count=%0d votes=%0d held=%0d",
                                     want.present, want.changed, want.close_count,
                                     want.present_votes, want.votes_held);
                            $display("  got present=%0d changed=%0d count=%0d votes=%0d held=%0d pad=%h",
                                     got.present, got.changed, got.close_count,
                                     got.present_votes, got.votes_held,
                                     i_out_data[OUT_TDATA_W-1:$bits(t_result)]);
                        end
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLOSE_STRENGTH_MIN: close_min = i_cfg_wdata;
                    CFG_PRESENCE_COUNT_MIN: count_min = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                rssi = i_in_data;
                // zero strength means unknown distance and counts as close
                if (i_in_user && (rssi == 0 || rssi >= close_min) && close_in_scan != COUNT_LIMIT)
                    close_in_scan++;
                if (i_in_last) begin
                    vote = (close_in_scan >= count_min);
                    vote_window[window_ptr] = vote;
                    window_ptr = (window_ptr == VOTE_SLOTS - 1) ? '0 : window_ptr + 1'b1;
                    if (window_fill < VOTE_SLOTS)
                        window_fill++;
                    votes = $countones(vote_window);
                    want.present       = (2 * votes >= window_fill);
                    want.changed       = (want.present != presence_now);
                    want.close_count   = close_in_scan;
                    want.present_votes = votes[3:0];
                    want.votes_held    = window_fill;
                    presence_now       = want.present;
                    expected_decisions.insert(expected_decisions.size(), want);
                    close_in_scan = '0;
                end
            end
        end
        o_pending = expected_decisions.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, device report stimulus, result sink and the verdict.
module tb;
    import pcpv_pkg::*;

    localparam int unsigned VOTE_SLOTS     = 12;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 175;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned idle_cycles;
    int unsigned sent_items;
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned rx_hold_reqs;

    logic signed [STRENGTH_W-1:0] cur_close;

    proximity_count_presence_voter #(
        .WINDOW_SLOTS(VOTE_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    presence_vote_checker #(
        .VOTE_SLOTS(VOTE_SLOTS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_in_user   (s_tuser),
        .i_in_last   (s_tlast),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result sink; each new hold-off request parks tready low for a long stretch
    initial begin
        int unsigned holds_done;
        holds_done = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_reqs != holds_done) begin
                holds_done = rx_hold_reqs;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // cycles with no transaction on either side; at WATCHDOG_LIMIT the test ends
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called and left at a falling edge
    task automatic send_item(input logic has_dev, input logic signed [7:0] rssi, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rssi;
        s_tuser  <= has_dev;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    // stop offering and let every outstanding scan result drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_CLOSE_STRENGTH_MIN)
            cur_close = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_report(input logic last);
        t_in_item it;
        int       s;
        it.has_device = ($urandom_range(7) != 0);
        it.scan_end   = last;
        case ($urandom_range(5))
            0:       s = 0;
            1:       s = $urandom_range(1) ? 127 : -128;
            2, 3:    s = int'(cur_close) + int'($urandom_range(6)) - 3;
            default: s = int'($urandom_range(255)) - 128;
        endcase
        if (s > 127)
            s = 127;
        if (s < -128)
            s = -128;
        it.strength = s[7:0];
        return it;
    endfunction

    task automatic send_scan(input int unsigned n_dev);
        t_in_item it;
        repeat (n_dev) begin
            it = make_report(1'b0);
            send_item(it.has_device, it.strength, it.scan_end);
        end
        it = make_report(1'b1);
        send_item(it.has_device, it.strength, it.scan_end);
    endtask

    initial begin
        logic signed [STRENGTH_W-1:0] c;
        logic [COUNT_W-1:0]           n;
        int unsigned                  phase_start;
        bit                           paused;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        sent_items   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_reqs = 0;
        cur_close    = CLOSE_STRENGTH_MIN_RST;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: empty scan, then threshold edges and an ignored strength
        send_item(1'b0, 8'sd0, 1'b1);
        send_item(1'b1, -8'sd71, 1'b0);
        send_item(1'b1, -8'sd72, 1'b0);
        send_item(1'b1, 8'sd0, 1'b0);
        send_item(1'b1, 8'sd127, 1'b0);
        send_item(1'b1, -8'sd128, 1'b0);
        send_item(1'b0, 8'sd127, 1'b0);
        // device and scan end in one transaction
        send_item(1'b1, -8'sd71, 1'b1);

        // threshold of zero votes present even for an empty scan
        wait_quiet();
        write_reg(CFG_PRESENCE_COUNT_MIN, 8'd0);
        send_item(1'b0, -8'sd1, 1'b1);

        // close minimum at the top strength: only zero and 127 still count
        wait_quiet();
        write_reg(CFG_CLOSE_STRENGTH_MIN, 8'sd127);
        write_reg(CFG_PRESENCE_COUNT_MIN, 8'd1);
        send_item(1'b1, 8'sd0, 1'b0);
        send_item(1'b1, 8'sd127, 1'b0);
        send_item(1'b1, 8'sd126, 1'b0);
        send_item(1'b0, 8'sd0, 1'b1);

        wait_quiet();
        write_reg(CFG_CLOSE_STRENGTH_MIN, -8'sd128);
        write_reg(CFG_PRESENCE_COUNT_MIN, 8'd255);
        send_item(1'b1, -8'sd128, 1'b1);

        wait_quiet();
        write_reg(CFG_CLOSE_STRENGTH_MIN, 8'sd0);
        write_reg(CFG_PRESENCE_COUNT_MIN, 8'd1);
        send_item(1'b1, 8'sd1, 1'b0);
        send_item(1'b1, -8'sd1, 1'b0);
        send_item(1'b1, 8'sd0, 1'b1);
        send_item(1'b1, -8'sd1, 1'b1);

        for (int phase = 0; phase < 8; phase++) begin
            wait_quiet();
            case (phase)
                0: begin c = -8'sd71;  n = 8'd3;   end
                1: begin c = -8'sd128; n = 8'd1;   end
                2: begin c = 8'sd127;  n = 8'd0;   end
                3: begin c = -8'sd59;  n = 8'd2;   end
                4: begin c = 8'sd0;    n = 8'd255; end
                5: begin c = -8'sd128; n = 8'd255; end
                6: begin c = -8'sd90;  n = 8'd2;   end
                default: begin
                    c = 8'($urandom_range(255));
                    n = 8'($urandom_range(5));
                end
            endcase
            write_reg(CFG_CLOSE_STRENGTH_MIN, c);
            write_reg(CFG_PRESENCE_COUNT_MIN, n);
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            // sink holds off while reports keep coming, so the input backs up
            if (phase == 2)
                rx_hold_reqs++;
            // one very long scan drives the close count into saturation
            if (phase == 5) begin
                repeat (300) send_item(1'b1, 8'($urandom_range(255)), 1'b0);
                send_item(1'b1, 8'sd0, 1'b1);
            end
            phase_start = sent_items;
            paused = 1'b0;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                if (phase == 1 && !paused && sent_items - phase_start >= PHASE_ITEMS / 2) begin
                    wait_quiet();
                    paused = 1'b1;
                end
                if ($urandom_range(9) == 0) begin
                    // stray transaction with no device and no scan end
                    send_item(1'b0, 8'($urandom_range(255)), 1'b0);
                end else if ($urandom_range(7) == 0) begin
                    send_scan($urandom_range(20, 8));
                end else begin
                    send_scan($urandom_range(7));
                end
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
